@@ hw/rtl/bit_rate_to_qos_code_converter_core_macros.svh @@
// assertion macros for the bit rate to qos code converter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BIT_RATE_TO_QOS_CODE_CONVERTER_CORE_MACROS_SVH
`define BIT_RATE_TO_QOS_CODE_CONVERTER_CORE_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define BRQOS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brqos implication check failed");

// plain invariant checked at every rising clock edge outside reset
`define BRQOS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("brqos invariant check failed");

`endif

@@ hw/rtl/brqos_pkg.sv @@
// types and constants for the bit rate to qos code converter
// no dependencies; used by the core and its checker
package brqos_pkg;

    localparam int K_W = 23;  // kbit/s value, max 4294967

    typedef struct packed {
        logic [7:0]  bearer_class;
        logic [31:0] max_rate_dl_bps;
        logic [31:0] max_rate_ul_bps;
        logic [31:0] guar_rate_dl_bps;
        logic [31:0] guar_rate_ul_bps;
        logic        default_bearer;
    } brqos_req_t;

    typedef struct packed {
        logic [7:0] class_out;
        logic       rates_present;
        logic       ext_present;
        logic [7:0] max_ul_code;
        logic [7:0] max_dl_code;
        logic [7:0] guar_ul_code;
        logic [7:0] guar_dl_code;
        logic [7:0] max_ul_ext_code;
        logic [7:0] max_dl_ext_code;
        logic [7:0] guar_ul_ext_code;
        logic [7:0] guar_dl_ext_code;
    } brqos_rsp_t;

    localparam logic [7:0] CODE_ZERO_RATE = 8'hFF;
    localparam logic [7:0] CODE_EXT_RATE  = 8'hFE;

    localparam logic [K_W-1:0] K_LOW_TOP   = 23'd63;
    localparam logic [K_W-1:0] K_MID_BASE  = 23'd64;
    localparam logic [K_W-1:0] K_MID_TOP   = 23'd575;
    localparam logic [K_W-1:0] K_HIGH_BASE = 23'd576;
    localparam logic [K_W-1:0] K_BASE_TOP  = 23'd8640;
    localparam logic [K_W-1:0] K_EXT1_OFS  = 23'd8600;
    localparam logic [K_W-1:0] K_EXT1_TOP  = 23'd16000;
    localparam logic [K_W-1:0] K_EXT2_TOP  = 23'd128000;
    localparam logic [K_W-1:0] K_EXT3_TOP  = 23'd256000;

    localparam logic [7:0] CODE_MID_OFS  = 8'd64;
    localparam logic [7:0] CODE_HIGH_OFS = 8'd128;
    localparam logic [7:0] CODE_EXT2_OFS = 8'd74;
    localparam logic [7:0] CODE_EXT3_OFS = 8'd186;

    // reciprocals: x/1000 = ((x>>3)*R)>>36, x/100 = ((x>>2)*R)>>16,
    // x/1000 (narrow) = ((x>>3)*R)>>21, x/2000 = ((x>>4)*R)>>20
    localparam logic [29:0] RECIP_1000_WIDE = 30'd549755814;
    localparam logic [11:0] RECIP_100       = 12'd2622;
    localparam logic [14:0] RECIP_1000      = 15'd16778;
    localparam logic [13:0] RECIP_2000      = 14'd8389;

endpackage

@@ hw/rtl/bit_rate_to_qos_code_converter_core.sv @@
// bit rate to qos code converter: four rate lanes, three register stages
// depends on brqos_pkg
//
// usage: drive request and pulse start; an item is taken at a clock edge
// where start is high and busy is low. busy is high only in the cycle
// leaving reset, so a new item may be taken every cycle after that.
// each item yields one result beat on result, marked by done for exactly
// one cycle, once it has passed the input register, kbit/s register and
// code register. throughput is one item per cycle.
// the kbit/s stage holds one 29x30 reciprocal multiply per lane; the code
// stage holds the narrow reciprocal multiplies for the extension ranges.
// the receiver cannot stall; every result is taken in its done cycle.
// reset clears the valid pipeline and drops any items in flight; result
// fields are not cleared and only mean something while done is high.
module bit_rate_to_qos_code_converter_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  brqos_pkg::brqos_req_t request,
    output logic                 done,
    output brqos_pkg::brqos_rsp_t result
);
    import brqos_pkg::*;

    function automatic logic [7:0] base_code(input logic [K_W-1:0] k);
        logic [K_W-1:0] dm;
        logic [K_W-1:0] dh;
        logic [7:0]     code;
        dm = k - K_MID_BASE;
        dh = k - K_HIGH_BASE;
        if (k == '0)
        begin
            code = CODE_ZERO_RATE;
        end
        else if (k <= K_LOW_TOP)
        begin
            code = k[7:0];
        end
        else if (k <= K_MID_TOP)
        begin
            code = {2'b00, dm[8:3]} + CODE_MID_OFS;
        end
        else if (k <= K_BASE_TOP)
        begin
            code = {1'b0, dh[12:6]} + CODE_HIGH_OFS;
        end
        else
        begin
            code = CODE_EXT_RATE;
        end
        return code;
    endfunction

    function automatic logic [7:0] ext_code(input logic [K_W-1:0] k);
        logic [K_W-1:0] d1;
        logic [K_W-1:0] d2;
        logic [K_W-1:0] d3;
        logic [22:0]    p1;
        logic [28:0]    p2;
        logic [26:0]    p3;
        logic [7:0]     code;
        d1 = k - K_EXT1_OFS;
        d2 = k - K_EXT1_TOP;
        d3 = k - K_EXT2_TOP;
        p1 = 23'(d1[12:2]) * 23'(RECIP_100);
        p2 = 29'(d2[16:3]) * 29'(RECIP_1000);
        p3 = 27'(d3[16:4]) * 27'(RECIP_2000);
        if (k <= K_BASE_TOP)
        begin
            code = '0;
        end
        else if (k <= K_EXT1_TOP)
        begin
            code = {1'b0, p1[22:16]};
        end
        else if (k <= K_EXT2_TOP)
        begin
            code = {1'b0, p2[27:21]} + CODE_EXT2_OFS;
        end
        else if (k <= K_EXT3_TOP)
        begin
            code = {1'b0, p3[26:20]} + CODE_EXT3_OFS;
        end
        else
        begin
            code = '0;
        end
        return code;
    endfunction

    // lane order: max ul, max dl, guar ul, guar dl
    localparam int LANES = 4;

    logic                 busy_reg;
    logic                 in_vld_reg;
    logic                 in_vld_next;
    brqos_req_t           req_reg;
    logic                 k_vld_reg;
    logic [K_W-1:0]       k_reg [LANES];
    logic [K_W-1:0]       k_next [LANES];
    logic [7:0]           cls_reg;
    logic                 dflt_reg;
    logic                 done_reg;
    brqos_rsp_t           rsp_reg;
    brqos_rsp_t           rsp_next;
    logic [31:0]          rate [LANES];
    logic [58:0]          prod [LANES];
    logic [7:0]           bcode [LANES];
    logic [7:0]           ecode [LANES];
    logic                 any_ext;

    assign in_vld_next = start && !busy_reg;

    assign rate[0] = req_reg.max_rate_ul_bps;
    assign rate[1] = req_reg.max_rate_dl_bps;
    assign rate[2] = req_reg.guar_rate_ul_bps;
    assign rate[3] = req_reg.guar_rate_dl_bps;

    // kbit/s = bps / 1000 through a reciprocal multiply
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i]   = 59'(rate[i][31:3]) * 59'(RECIP_1000_WIDE);
            k_next[i] = prod[i][58:36];
        end
    end

    always_comb
    begin
        any_ext = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            bcode[i] = base_code(k_reg[i]);
            ecode[i] = ext_code(k_reg[i]);
            any_ext  = any_ext | (k_reg[i] > K_BASE_TOP);
        end
        rsp_next                  = '0;
        rsp_next.class_out        = cls_reg;
        if (!dflt_reg)
        begin
            rsp_next.rates_present    = 1'b1;
            rsp_next.ext_present      = any_ext;
            rsp_next.max_ul_code      = bcode[0];
            rsp_next.max_dl_code      = bcode[1];
            rsp_next.guar_ul_code     = bcode[2];
            rsp_next.guar_dl_code     = bcode[3];
            rsp_next.max_ul_ext_code  = ecode[0];
            rsp_next.max_dl_ext_code  = ecode[1];
            rsp_next.guar_ul_ext_code = ecode[2];
            rsp_next.guar_dl_ext_code = ecode[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            in_vld_reg <= 1'b0;
            k_vld_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= 1'b0;
            in_vld_reg <= in_vld_next;
            k_vld_reg  <= in_vld_reg;
            done_reg   <= k_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_next)
        begin
            req_reg <= request;
        end
        if (in_vld_reg)
        begin
            k_reg    <= k_next;
            cls_reg  <= req_reg.bearer_class;
            dflt_reg <= req_reg.default_bearer;
        end
        if (k_vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

@@ hw/rtl/brqos_chk.sv @@
// port-level checker for the bit rate to qos code converter, bound to the core
// depends on brqos_pkg and bit_rate_to_qos_code_converter_core_macros.svh
`include "bit_rate_to_qos_code_converter_core_macros.svh"

module brqos_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input brqos_pkg::brqos_req_t request,
    input logic                  done,
    input brqos_pkg::brqos_rsp_t result
);
    import brqos_pkg::*;

    logic [8:0] item_tag;
    logic [8:0] beat_tag;
    logic       any_ext_code;
    logic       codes_clear;

    assign item_tag = {request.bearer_class, !request.default_bearer};
    assign beat_tag = {result.class_out, result.rates_present};

    assign any_ext_code = (result.max_ul_code == CODE_EXT_RATE) ||
                          (result.max_dl_code == CODE_EXT_RATE) ||
                          (result.guar_ul_code == CODE_EXT_RATE) ||
                          (result.guar_dl_code == CODE_EXT_RATE);

    assign codes_clear = !result.ext_present &&
                         (result.max_ul_code == '0) && (result.max_dl_code == '0) &&
                         (result.guar_ul_code == '0) && (result.guar_dl_code == '0) &&
                         (result.max_ul_ext_code == '0) && (result.max_dl_ext_code == '0) &&
                         (result.guar_ul_ext_code == '0) && (result.guar_dl_ext_code == '0);

    // every result beat traces back to an accepted item
    `BRQOS_ASSERT_IMPL(a_done_has_item, done, $past(start && !busy, 3))

    // class and bearer kind follow the item that produced the beat
    `BRQOS_ASSERT_IMPL(a_class_kind, done, beat_tag == $past(item_tag, 3))

    // a default bearer carries no codes at all
    `BRQOS_ASSERT_ALWAYS(a_default_clear, !done || result.rates_present || codes_clear)

    // extension flag implies some base code is the extension marker
    // the top of the base range also codes as the marker, so no converse
    `BRQOS_ASSERT_IMPL(a_ext_flag, done && result.ext_present, any_ext_code)

endmodule

bind bit_rate_to_qos_code_converter_core brqos_chk u_brqos_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

@@ dv/tb_top.sv @@
// testbench for the bit rate to qos code converter core
// depends on brqos_pkg and bit_rate_to_qos_code_converter_core
// directed rate boundaries and default bearers, then random bearers checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import brqos_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 10;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    brqos_req_t request;
    brqos_rsp_t result;

    brqos_rsp_t qos_codes_q[$];
    int         accepted_beats;
    int         result_beats;
    int         mismatches;
    int         idle_cycles;
    bit         gaps_on;

    bit_rate_to_qos_code_converter_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // base octet of a rate in kbit/s
    function automatic logic [7:0] base_octet(input int unsigned k);
        if (k == 0)
            return CODE_ZERO_RATE;
        if (k <= 63)
            return 8'(k);
        if (k <= 575)
            return 8'((k - 64) / 8 + 64);
        if (k <= 8640)
            return 8'((k - 576) / 64 + 128);
        return CODE_EXT_RATE;
    endfunction

    // extension octet, zero inside the base range and beyond 256000
    function automatic logic [7:0] ext_octet(input int unsigned k);
        if (k <= 8640)
            return 8'd0;
        if (k <= 16000)
            return 8'((k - 8600) / 100);
        if (k <= 128000)
            return 8'((k - 16000) / 1000 + 74);
        if (k <= 256000)
            return 8'((k - 128000) / 2000 + 186);
        return 8'd0;
    endfunction

    function automatic brqos_rsp_t predict_qos_codes(input brqos_req_t r);
        brqos_rsp_t  codes;
        int unsigned k_mdl;
        int unsigned k_mul;
        int unsigned k_gdl;
        int unsigned k_gul;
        k_mdl = r.max_rate_dl_bps / 1000;
        k_mul = r.max_rate_ul_bps / 1000;
        k_gdl = r.guar_rate_dl_bps / 1000;
        k_gul = r.guar_rate_ul_bps / 1000;
        codes = '0;
        codes.class_out = r.bearer_class;
        if (!r.default_bearer)
        begin
            codes.rates_present    = 1'b1;
            codes.ext_present      = (k_mdl > 8640) || (k_mul > 8640) ||
                                     (k_gdl > 8640) || (k_gul > 8640);
            codes.max_ul_code      = base_octet(k_mul);
            codes.max_dl_code      = base_octet(k_mdl);
            codes.guar_ul_code     = base_octet(k_gul);
            codes.guar_dl_code     = base_octet(k_gdl);
            codes.max_ul_ext_code  = ext_octet(k_mul);
            codes.max_dl_ext_code  = ext_octet(k_mdl);
            codes.guar_ul_ext_code = ext_octet(k_gul);
            codes.guar_dl_ext_code = ext_octet(k_gdl);
        end
        return codes;
    endfunction

    task automatic check_code(input string fname, input logic [7:0] got,
                              input logic [7:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("beat %0d: %s mismatch, expected %0h got %0h",
                         result_beats, fname, want, got);
        end
    endtask

    task automatic compare_codes(input brqos_rsp_t want, input brqos_rsp_t got);
        check_code("class_out", got.class_out, want.class_out);
        check_code("rates_present", 8'(got.rates_present), 8'(want.rates_present));
        check_code("ext_present", 8'(got.ext_present), 8'(want.ext_present));
        check_code("max_ul_code", got.max_ul_code, want.max_ul_code);
        check_code("max_dl_code", got.max_dl_code, want.max_dl_code);
        check_code("guar_ul_code", got.guar_ul_code, want.guar_ul_code);
        check_code("guar_dl_code", got.guar_dl_code, want.guar_dl_code);
        check_code("max_ul_ext_code", got.max_ul_ext_code, want.max_ul_ext_code);
        check_code("max_dl_ext_code", got.max_dl_ext_code, want.max_dl_ext_code);
        check_code("guar_ul_ext_code", got.guar_ul_ext_code, want.guar_ul_ext_code);
        check_code("guar_dl_ext_code", got.guar_dl_ext_code, want.guar_dl_ext_code);
    endtask

    // outputs and handshake sampled before the edge updates them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (qos_codes_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result beat with no bearer outstanding: %0h", result);
                end
                else
                    compare_codes(qos_codes_q.pop_front(), result);
                result_beats++;
            end
            if (start && !busy)
            begin
                qos_codes_q.push_back(predict_qos_codes(request));
                accepted_beats++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic brqos_req_t make_bearer(input logic [7:0] cls,
                                               input logic [31:0] mdl,
                                               input logic [31:0] mul,
                                               input logic [31:0] gdl,
                                               input logic [31:0] gul,
                                               input logic dflt);
        brqos_req_t r;
        r.bearer_class     = cls;
        r.max_rate_dl_bps  = mdl;
        r.max_rate_ul_bps  = mul;
        r.guar_rate_dl_bps = gdl;
        r.guar_rate_ul_bps = gul;
        r.default_bearer   = dflt;
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_bearer(input brqos_req_t r);
        if (gaps_on && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (result_beats != accepted_beats)
            @(negedge clk);
        @(posedge clk);
    endtask

    // picks a band first so every code range sees plenty of traffic
    function automatic logic [31:0] random_rate();
        longint unsigned k;
        longint unsigned bps;
        case ($urandom_range(7))
            0: k = $urandom_range(63);
            1: k = $urandom_range(575, 64);
            2: k = $urandom_range(8640, 576);
            3: k = $urandom_range(16000, 8641);
            4: k = $urandom_range(128000, 16001);
            5: k = $urandom_range(256000, 128001);
            6: k = $urandom_range(4294967, 256001);
            default: return $urandom;
        endcase
        bps = k * 1000 + $urandom_range(999);
        if (bps > 64'hFFFF_FFFF)
            bps = 64'hFFFF_FFFF;
        return 32'(bps);
    endfunction

    task automatic test_lane_boundaries();
        int unsigned edges[18] = '{
            0, 999, 1000, 63999, 64000, 575999, 576000, 8640999, 8641000,
            8699999, 8700000, 16000999, 16001000, 128000999, 128001000,
            256000999, 256001000, 32'hFFFF_FFFF
        };
        // each lane walks the whole list at a different offset
        for (int i = 0; i < 18; i++)
            send_bearer(make_bearer(8'(i * 15), edges[i], edges[(i + 5) % 18],
                                    edges[(i + 10) % 18], edges[(i + 15) % 18],
                                    1'b0));
    endtask

    task automatic test_default_bearer();
        send_bearer(make_bearer(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_bearer(make_bearer(8'h00, 32'd0, 32'd9000000, 32'd1000,
                                32'd300000000, 1'b1));
        send_bearer(make_bearer(8'h5A, 32'd8641000, 32'd64000, 32'd0,
                                32'd500000, 1'b1));
    endtask

    task automatic test_random_bearers(input int count);
        for (int i = 0; i < count; i++)
            send_bearer(make_bearer(8'($urandom_range(255)), random_rate(), random_rate(),
                                    random_rate(), random_rate(),
                                    $urandom_range(99) < 10));
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        test_random_bearers(count);
        gaps_on = 1'b1;
    endtask

    task automatic test_pause_until_drained(input int count);
        start <= 1'b0;
        wait_results_drained();
        test_random_bearers(count);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        request        <= '0;
        accepted_beats = 0;
        result_beats   = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lane_boundaries();
        test_default_bearer();
        test_random_bearers(600);
        test_back_to_back(500);
        test_pause_until_drained(730);

        start <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && qos_codes_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
